[rtl/core/fum_pkg.sv]
// Shared types, constants and sine table generator for the FSK UART modulator.
package fum_pkg;

    localparam int FIFO_DEPTH = 128;
    localparam int TABLE_SIZE = 256;
    localparam int DAC_BITS   = 12;

    localparam int FIFO_AW = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW = $clog2(FIFO_DEPTH + 1);
    localparam int PHASE_W = $clog2(TABLE_SIZE);
    localparam int STEP_W  = 8;
    localparam int PSUM_W  = ((PHASE_W > STEP_W) ? PHASE_W : STEP_W) + 1;
    localparam int SPB_W   = 16;
    localparam int BITN_W  = 4;
    localparam int DATA_BITS = 8;

    localparam logic [DAC_BITS-1:0] HELD_RESET = DAC_BITS'(((1 << DAC_BITS) - 1) / 2);

    localparam logic [STEP_W-1:0] MARK_STEP_RESET  = 8'd16;
    localparam logic [STEP_W-1:0] SPACE_STEP_RESET = 8'd29;
    localparam logic [SPB_W-1:0]  SPB_RESET        = 16'd16;

    localparam int PADDR_W = 4;

    typedef enum logic [1:0] {
        REG_MARK_STEP  = 2'd0,
        REG_SPACE_STEP = 2'd1,
        REG_SPB        = 2'd2,
        REG_NONE       = 2'd3
    } t_reg_idx;

    typedef enum logic {
        KIND_TICK = 1'b0,
        KIND_PUSH = 1'b1
    } t_kind;

    typedef enum logic [1:0] {
        MODE_IDLE  = 2'd0,
        MODE_START = 2'd1,
        MODE_MARK  = 2'd2,
        MODE_SPACE = 2'd3
    } t_mode;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] data_byte;
    } t_in_word;

    typedef struct packed {
        logic [DAC_BITS-1:0] dac_sample;
        logic                sample_valid;
        logic                push_accepted;
        logic                tone_is_space;
        logic [1:0]          frame_phase;
    } t_out_word;

    typedef struct packed {
        logic [STEP_W-1:0] mark_step;
        logic [STEP_W-1:0] space_step;
        logic [SPB_W-1:0]  bit_ticks;
    } t_cfg;

    typedef struct packed {
        logic       empty;
        logic       full;
        logic [7:0] head_data;
    } t_fifo_stat;

    typedef logic [DAC_BITS-1:0] t_sine_rom [TABLE_SIZE];

    localparam logic [7:0] TAYLOR_DIV [6] = '{8'd6, 8'd20, 8'd42, 8'd72, 8'd110, 8'd156};

    // Q30 Taylor sine, folded to the first quadrant
    function automatic logic [DAC_BITS-1:0] sine_entry(int unsigned i);
        logic [63:0] one;
        logic [63:0] quarter;
        logic [63:0] half;
        logic [63:0] mid;
        logic [63:0] amp;
        logic [63:0] t;
        logic [63:0] u;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] mag;
        longint      sum;
        logic        neg;
        one     = 64'd1 << 32;
        quarter = one >> 2;
        half    = one >> 1;
        mid     = 64'd1 << (DAC_BITS - 1);
        amp     = mid - 64'd1;
        t       = (64'(i % TABLE_SIZE) << 32) / TABLE_SIZE;
        if (t < quarter) begin
            u = t;
            neg = 1'b0;
        end else if (t < half) begin
            u = half - t;
            neg = 1'b0;
        end else if (t < half + quarter) begin
            u = t - half;
            neg = 1'b1;
        end else begin
            u = one - t;
            neg = 1'b1;
        end
        x    = (u * 64'd1686629713) >> 30;
        x2   = (x * x) >> 30;
        term = x;
        sum  = longint'(x);
        for (int k = 1; k <= 6; k++) begin
            term = (term * x2) >> 30;
            term = term / 64'(TAYLOR_DIV[k-1]);
            if ((k % 2) == 1) begin
                sum = sum - longint'(term);
            end else begin
                sum = sum + longint'(term);
            end
        end
        if (sum < 0) begin
            sum = 0;
        end
        if (sum > (longint'(1) << 30)) begin
            sum = longint'(1) << 30;
        end
        mag = (amp * 64'(sum) + (64'd1 << 29)) >> 30;
        return neg ? DAC_BITS'(mid - mag) : DAC_BITS'(mid + mag);
    endfunction

    function automatic t_sine_rom gen_sine_rom();
        t_sine_rom rom;
        for (int unsigned i = 0; i < TABLE_SIZE; i++) begin
            rom[i] = sine_entry(i);
        end
        return rom;
    endfunction

    localparam t_sine_rom SINE_ROM = gen_sine_rom();

endpackage

[rtl/core/fum_fifo.sv]
// Byte FIFO with registered head read and write-through bypass.
module fum_fifo (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  logic [7:0]          i_data,
    input  logic                i_pop,
    output fum_pkg::t_fifo_stat o_stat
);
    import fum_pkg::*;

    logic [7:0]         mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_head, n_head;
    logic [FIFO_AW-1:0] r_tail, n_tail;
    logic [FIFO_CW-1:0] r_count, n_count;
    logic [7:0]         r_head_data;
    logic               full;
    logic               empty;
    logic               wr_en;

    assign full  = (r_count == FIFO_CW'(FIFO_DEPTH));
    assign empty = (r_count == '0);
    assign wr_en = i_push && !full;

    always_comb begin
        n_head  = r_head;
        n_tail  = r_tail;
        n_count = r_count;
        if (wr_en) begin
            n_tail  = FIFO_AW'(r_tail + 1'b1);
            n_count = r_count + 1'b1;
        end else if (i_pop && !empty) begin
            n_head  = FIFO_AW'(r_head + 1'b1);
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[r_tail] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en && (r_tail == n_head)) begin
            r_head_data <= i_data;
        end else begin
            r_head_data <= mem[n_head];
        end
    end

    assign o_stat.empty     = empty;
    assign o_stat.full      = full;
    assign o_stat.head_data = r_head_data;

endmodule

[rtl/core/fum_framer.sv]
// UART framing, phase accumulator and sine lookup; forms one result per word.
module fum_framer (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  fum_pkg::t_in_word   i_word,
    input  fum_pkg::t_cfg       i_cfg,
    input  fum_pkg::t_fifo_stat i_fifo,
    output logic                o_pop,
    output fum_pkg::t_out_word  o_result
);
    import fum_pkg::*;

    t_mode               r_mode, n_mode;
    logic [BITN_W-1:0]   r_bitn, n_bitn;
    logic [SPB_W-1:0]    r_count, n_count;
    logic [7:0]          r_shift, n_shift;
    logic [PHASE_W-1:0]  r_phase, n_phase;
    logic [DAC_BITS-1:0] r_held, n_held;
    logic [SPB_W-1:0]    cnt_inc;
    logic                ends;
    logic                tick;
    logic                space;
    logic [STEP_W-1:0]   step;

    assign tick    = i_accept && (i_word.kind == KIND_TICK);
    assign cnt_inc = r_count + 1'b1;
    assign ends    = (cnt_inc >= i_cfg.bit_ticks);

    always_comb begin
        n_mode  = r_mode;
        n_bitn  = r_bitn;
        n_count = r_count;
        n_shift = r_shift;
        n_phase = r_phase;
        n_held  = r_held;
        space   = 1'b0;
        o_pop   = 1'b0;
        step    = i_cfg.mark_step;
        if (tick) begin
            n_count = cnt_inc;
            unique case (r_mode)
                MODE_IDLE: begin
                    if (ends) begin
                        n_count = SPB_W'(1);
                        if (!i_fifo.empty) begin
                            o_pop   = 1'b1;
                            n_shift = i_fifo.head_data;
                            space   = 1'b1;
                            n_mode  = MODE_START;
                        end
                    end
                end
                MODE_START: begin
                    space = 1'b1;
                    if (ends) begin
                        n_count = SPB_W'(1);
                        n_bitn  = '0;
                        space   = !r_shift[0];
                        n_mode  = space ? MODE_SPACE : MODE_MARK;
                    end
                end
                MODE_MARK, MODE_SPACE: begin
                    space = (r_mode == MODE_SPACE);
                    if (ends) begin
                        n_count = SPB_W'(1);
                        n_bitn  = r_bitn + 1'b1;
                        if (n_bitn >= BITN_W'(DATA_BITS)) begin
                            space  = 1'b0;
                            n_mode = MODE_IDLE;
                        end else begin
                            space  = !r_shift[n_bitn[2:0]];
                            n_mode = space ? MODE_SPACE : MODE_MARK;
                        end
                    end
                end
                default: begin
                    n_mode = MODE_IDLE;
                end
            endcase
            step    = space ? i_cfg.space_step : i_cfg.mark_step;
            n_held  = SINE_ROM[r_phase];
            n_phase = PHASE_W'(PSUM_W'(r_phase) + PSUM_W'(step));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_IDLE;
            r_bitn  <= '0;
            r_count <= '0;
            r_shift <= '0;
            r_phase <= '0;
            r_held  <= HELD_RESET;
        end else begin
            r_mode  <= n_mode;
            r_bitn  <= n_bitn;
            r_count <= n_count;
            r_shift <= n_shift;
            r_phase <= n_phase;
            r_held  <= n_held;
        end
    end

    assign o_result.dac_sample    = n_held;
    assign o_result.sample_valid  = tick;
    assign o_result.push_accepted = i_accept && (i_word.kind == KIND_PUSH) && !i_fifo.full;
    assign o_result.tone_is_space = tick && space;
    assign o_result.frame_phase   = n_mode;

endmodule

[rtl/core/fum_out_buf.sv]
// Two-entry output buffer: result register plus skid register.
module fum_out_buf (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  fum_pkg::t_out_word i_word,
    output logic               o_ready,
    output logic               o_valid,
    output fum_pkg::t_out_word o_word,
    input  logic               i_ready
);
    import fum_pkg::*;

    logic      r_main_valid, n_main_valid;
    logic      r_skid_valid, n_skid_valid;
    t_out_word r_main, n_main;
    t_out_word r_skid, n_skid;
    logic      take;

    assign take = r_main_valid && i_ready;

    always_comb begin
        n_main_valid = r_main_valid;
        n_skid_valid = r_skid_valid;
        n_main       = r_main;
        n_skid       = r_skid;
        if (take) begin
            if (r_skid_valid) begin
                n_main       = r_skid;
                n_skid_valid = 1'b0;
            end else begin
                n_main_valid = i_push;
                n_main       = i_word;
            end
        end else if (i_push) begin
            if (!r_main_valid) begin
                n_main_valid = 1'b1;
                n_main       = i_word;
            end else begin
                n_skid_valid = 1'b1;
                n_skid       = i_word;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_main_valid <= n_main_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_main <= n_main;
        r_skid <= n_skid;
    end

    assign o_ready = !r_skid_valid;
    assign o_valid = r_main_valid;
    assign o_word  = r_main;

endmodule

[rtl/core/fsk_uart_modulator.sv]
// Top level: APB register file, byte FIFO, framer and output buffer.
// Each word's result is registered in the output buffer and shows at o_out_valid once it enters the result register.
// Throughput: one word per cycle while o_in_ready is high; the framer updates its state on each accepted tick word.
// A stalled result leaves room for one more word in the skid register before o_in_ready drops.
// Reset (synchronous, active low) clears control state and restores register defaults;
// FIFO storage is not cleared and needs no clearing pass.
module fsk_uart_modulator (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  fum_pkg::t_in_word            i_in_word,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output fum_pkg::t_out_word           o_out_word,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [fum_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);
    import fum_pkg::*;

    logic [STEP_W-1:0] r_mark;
    logic [STEP_W-1:0] r_space;
    logic [SPB_W-1:0]  r_spb;
    t_cfg              cfg;
    t_reg_idx          reg_idx;
    logic              wr_en;
    logic              accept;
    logic              pop;
    t_fifo_stat        fifo_stat;
    t_out_word         result;

    assign pready  = 1'b1;
    assign reg_idx = t_reg_idx'(paddr[3:2]);
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mark  <= MARK_STEP_RESET;
            r_space <= SPACE_STEP_RESET;
            r_spb   <= SPB_RESET;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_MARK_STEP:  r_mark  <= pwdata[STEP_W-1:0];
                REG_SPACE_STEP: r_space <= pwdata[STEP_W-1:0];
                REG_SPB:        r_spb   <= pwdata[SPB_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_MARK_STEP:  prdata = {24'd0, r_mark};
            REG_SPACE_STEP: prdata = {24'd0, r_space};
            REG_SPB:        prdata = {16'd0, r_spb};
            default:        prdata = '0;
        endcase
    end

    assign cfg.mark_step  = r_mark;
    assign cfg.space_step = r_space;
    assign cfg.bit_ticks  = r_spb;

    assign accept = i_in_valid && o_in_ready;

    fum_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept && (i_in_word.kind == KIND_PUSH)),
        .i_data  (i_in_word.data_byte),
        .i_pop   (pop),
        .o_stat  (fifo_stat)
    );

    fum_framer u_framer (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_word   (i_in_word),
        .i_cfg    (cfg),
        .i_fifo   (fifo_stat),
        .o_pop    (pop),
        .o_result (result)
    );

    fum_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_word  (result),
        .o_ready (o_in_ready),
        .o_valid (o_out_valid),
        .o_word  (o_out_word),
        .i_ready (i_out_ready)
    );

endmodule

[sim/fsk_uart_modulator_test.sv]
`timescale 1ns / 1ps
// Self-checking testbench for fsk_uart_modulator with a framing scoreboard.
module fsk_uart_modulator_test;
    import fum_pkg::*;

    localparam int HOLD_CYCLES = 80;
    localparam int STALL_LIMIT = 1000;

    class fsk_scoreboard;
        logic [STEP_W-1:0]   mark_step;
        logic [STEP_W-1:0]   space_step;
        logic [SPB_W-1:0]    bit_len;
        logic [7:0]          byte_fifo [FIFO_DEPTH];
        int                  rd_ptr;
        int                  wr_ptr;
        int                  fill;
        int                  phase;
        t_mode               mode;
        logic [BITN_W-1:0]   bit_idx;
        logic [SPB_W-1:0]    tick_cnt;
        logic [7:0]          tx_byte;
        logic [DAC_BITS-1:0] sine [TABLE_SIZE];
        logic [DAC_BITS-1:0] last_sample;
        logic                last_space;
        t_out_word           predicted_words [$];
        int                  mismatches;

        function new();
            for (int i = 0; i < TABLE_SIZE; i++) begin
                sine[i] = sine_value(i);
            end
            mark_step   = MARK_STEP_RESET;
            space_step  = SPACE_STEP_RESET;
            bit_len     = SPB_RESET;
            rd_ptr      = 0;
            wr_ptr      = 0;
            fill        = 0;
            phase       = 0;
            mode        = MODE_IDLE;
            bit_idx     = '0;
            tick_cnt    = '0;
            tx_byte     = '0;
            last_sample = DAC_BITS'(((1 << DAC_BITS) - 1) / 2);
            last_space  = 1'b0;
            mismatches  = 0;
        endfunction

        // Q30 Taylor series, folded into the first quadrant
        function logic [DAC_BITS-1:0] sine_value(int idx);
            longint unsigned full_turn;
            longint unsigned mid;
            longint unsigned t;
            longint unsigned u;
            longint unsigned x;
            longint unsigned x2;
            longint unsigned term;
            longint unsigned mag;
            longint          acc;
            bit              lower;
            full_turn = 64'd1 << 32;
            mid       = 64'd1 << (DAC_BITS - 1);
            t         = (longint'(idx % TABLE_SIZE) << 32) / TABLE_SIZE;
            lower     = (t >= full_turn / 2);
            if (lower) begin
                t = t - full_turn / 2;
            end
            u    = (t < full_turn / 4) ? t : full_turn / 2 - t;
            x    = (u * 64'd1686629713) >> 30;
            x2   = (x * x) >> 30;
            term = x;
            acc  = longint'(x);
            for (int k = 1; k <= 6; k++) begin
                term = (term * x2) >> 30;
                term = term / longint'((2 * k) * (2 * k + 1));
                acc  = (k % 2 == 1) ? acc - longint'(term) : acc + longint'(term);
            end
            if (acc < 0) begin
                acc = 0;
            end
            if (acc > (longint'(1) << 30)) begin
                acc = longint'(1) << 30;
            end
            mag = ((mid - 1) * longint'(acc) + (64'd1 << 29)) >> 30;
            return lower ? DAC_BITS'(mid - mag) : DAC_BITS'(mid + mag);
        endfunction

        function void write_reg(t_reg_idx idx, logic [31:0] value);
            case (idx)
                REG_MARK_STEP: begin
                    mark_step = value[STEP_W-1:0];
                end
                REG_SPACE_STEP: begin
                    space_step = value[STEP_W-1:0];
                end
                REG_SPB: begin
                    bit_len = value[SPB_W-1:0];
                end
                default: begin
                end
            endcase
        endfunction

        function void emit_tone(bit space);
            last_sample = sine[phase];
            last_space  = space;
            phase = (phase + int'(space ? space_step : mark_step)) % TABLE_SIZE;
        endfunction

        function bit bit_over();
            tick_cnt = tick_cnt + 1'b1;
            return tick_cnt >= bit_len;
        endfunction

        function void start_data_bit();
            if (tx_byte[bit_idx[2:0]]) begin
                emit_tone(1'b0);
                mode = MODE_MARK;
            end else begin
                emit_tone(1'b1);
                mode = MODE_SPACE;
            end
        endfunction

        function void advance_tick();
            case (mode)
                MODE_IDLE: begin
                    if (!bit_over()) begin
                        emit_tone(1'b0);
                    end else begin
                        if (fill == 0) begin
                            emit_tone(1'b0);
                        end else begin
                            tx_byte = byte_fifo[rd_ptr];
                            rd_ptr  = (rd_ptr + 1) % FIFO_DEPTH;
                            fill--;
                            emit_tone(1'b1);
                            mode = MODE_START;
                        end
                        tick_cnt = 1;
                    end
                end
                MODE_START: begin
                    if (!bit_over()) begin
                        emit_tone(1'b1);
                    end else begin
                        bit_idx = '0;
                        start_data_bit();
                        tick_cnt = 1;
                    end
                end
                default: begin
                    if (!bit_over()) begin
                        emit_tone(mode == MODE_SPACE);
                    end else begin
                        bit_idx = bit_idx + 1'b1;
                        if (bit_idx >= DATA_BITS) begin
                            emit_tone(1'b0);
                            mode = MODE_IDLE;
                        end else begin
                            start_data_bit();
                        end
                        tick_cnt = 1;
                    end
                end
            endcase
        endfunction

        function void note_word(t_in_word w);
            t_out_word e;
            e = '0;
            if (w.kind == KIND_PUSH) begin
                if (fill < FIFO_DEPTH) begin
                    byte_fifo[wr_ptr] = w.data_byte;
                    wr_ptr = (wr_ptr + 1) % FIFO_DEPTH;
                    fill++;
                    e.push_accepted = 1'b1;
                end
            end else begin
                advance_tick();
                e.sample_valid  = 1'b1;
                e.tone_is_space = last_space;
            end
            e.dac_sample  = last_sample;
            e.frame_phase = mode;
            predicted_words.push_back(e);
        endfunction

        function void check_word(t_out_word got);
            t_out_word e;
            if (predicted_words.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected output word %h", got);
                end
                return;
            end
            e = predicted_words.pop_front();
            if (got.dac_sample !== e.dac_sample || got.sample_valid !== e.sample_valid ||
                got.push_accepted !== e.push_accepted ||
                got.tone_is_space !== e.tone_is_space || got.frame_phase !== e.frame_phase) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("mismatch at %0t (exp/act): sample %0d/%0d valid %b/%b acc %b/%b",
                             $realtime, e.dac_sample, got.dac_sample, e.sample_valid,
                             got.sample_valid, e.push_accepted, got.push_accepted);
                    $display("    space %b/%b phase %0d/%0d",
                             e.tone_is_space, got.tone_is_space, e.frame_phase,
                             got.frame_phase);
                end
            end
        endfunction
    endclass

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_ready;
    t_in_word            in_word = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    t_out_word           out_word;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [PADDR_W-1:0]  paddr = '0;
    logic [31:0]         pwdata = '0;
    logic [31:0]         prdata;
    logic                pready;

    bit                  gaps_on = 1'b0;
    bit                  hold_req = 1'b0;
    int                  stall_cycles = 0;
    fsk_scoreboard       sb = new();

    fsk_uart_modulator u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_word  (out_word),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always #5 clk = ~clk;

    always @(posedge clk) begin
        if (rst_n) begin
            if (in_valid && in_ready) begin
                sb.note_word(in_word);
            end
            if (out_valid && out_ready) begin
                sb.check_word(out_word);
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles == STALL_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
            $display("Simulation FAILED");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // result side: random stalls, plus one long hold-off on request
    initial begin
        forever begin
            @(posedge clk);
            if (hold_req) begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end else begin
                out_ready <= !(gaps_on && $urandom_range(0, 99) < 20);
            end
        end
    end

    function automatic t_in_word make_word(t_kind kind, logic [7:0] data);
        t_in_word w;
        w.kind      = kind;
        w.data_byte = data;
        return w;
    endfunction

    task automatic send_word(t_in_word w);
        if (gaps_on && $urandom_range(0, 99) < 20) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic send_ticks(int count);
        repeat (count) send_word(make_word(KIND_TICK, 8'($urandom_range(0, 255))));
    endtask

    task automatic send_random(int count, int push_pct);
        t_kind kind;
        repeat (count) begin
            kind = ($urandom_range(0, 99) < push_pct) ? KIND_PUSH : KIND_TICK;
            send_word(make_word(kind, 8'($urandom_range(0, 255))));
        end
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.predicted_words.size() != 0) @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic reg_write(t_reg_idx idx, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'(4 * int'(idx));
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.write_reg(idx, value);
        @(posedge clk);
    endtask

    task automatic configure(int mark, int space, int bit_len);
        reg_write(REG_MARK_STEP, 32'(mark));
        reg_write(REG_SPACE_STEP, 32'(space));
        reg_write(REG_SPB, 32'(bit_len));
    endtask

    initial begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings, extremes of the data byte
        send_ticks(2);
        send_word(make_word(KIND_PUSH, 8'h00));
        send_word(make_word(KIND_PUSH, 8'hFF));
        send_ticks(2);
        drain();

        // zero mark step, full space step, every tick ends a bit
        configure(0, 255, 0);
        send_ticks(18);
        drain();

        gaps_on = 1'b1;
        configure(16, 29, 65535);
        send_random(250, 10);
        drain();

        // bit length lowered while a long idle bit is in progress
        configure($urandom_range(0, 255), $urandom_range(0, 255), 4);
        send_random(100, 15);
        hold_req = 1'b1;
        send_random(300, 15);
        drain();

        gaps_on = 1'b0;
        configure(255, 0, 1);
        send_random(300, 12);
        drain();
        gaps_on = 1'b1;

        // out-of-range register, then push-heavy traffic to overflow the queue
        reg_write(REG_NONE, $urandom);
        configure($urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(6, 12));
        send_random(400, 55);
        drain();

        configure($urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(1, 5));
        send_random(400, 10);
        drain();

        configure($urandom_range(0, 255), $urandom_range(0, 255), 2);
        send_random(250, 12);
        drain();

        repeat (5) @(posedge clk);
        if (sb.mismatches == 0 && sb.predicted_words.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
